/* rtl/core/gamma_correct_log_table_assert.svh */
// Assertion macros used by the gamma correction RTL.
`ifndef GAMMA_CORRECT_LOG_TABLE_ASSERT_SVH
`define GAMMA_CORRECT_LOG_TABLE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define GCL_ASSERT_IMPL(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("gamma correction check failed");

// Check that a condition implies a consequence in the next cycle.
`define GCL_ASSERT_NEXT(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("gamma correction check failed");

`endif

/* rtl/core/gcl_pkg.sv */
// Package for the gamma correction block: types, constants and the log ROM.
`timescale 1ns / 1ps

package gcl_pkg;

   localparam int LOG_TABLE_DEPTH = 510;
   localparam int FRAC_BITS       = 60;
   localparam int ROM_W           = 30;
   localparam int ADDR_W          = 9;
   localparam int PIXEL_W         = 8;
   localparam int GAMMA_W         = 16;
   localparam int MANT_W          = ROM_W - 14;
   localparam int PRODUCT_W       = MANT_W + GAMMA_W;
   localparam int SEARCH_STAGES   = ADDR_W;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd16384;
   localparam logic [63:0]        ROM_SCALE   = 64'h3fff_ffff;

   typedef logic [(1 << ADDR_W)-1:0][ROM_W-1:0] log_rom_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } gcl_ctl_type;

   // (a * b) >> FRAC_BITS, truncated to 64 bits
   function automatic logic [63:0] mul_fx(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // restoring unsigned division, den below 2^63
   function automatic logic [63:0] udiv_fx(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      int i;
      q = '0;
      r = '0;
      for (i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // floor(num / den * 2^FRAC_BITS)
   function automatic logic [63:0] div_fx(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] res;
      int b;
      q   = udiv_fx(num, den);
      rem = num - q * den;
      res = q << FRAC_BITS;
      for (b = FRAC_BITS - 1; b >= 0; b--) begin
         rem = rem << 1;
         if (rem >= den) begin
            rem    = rem - den;
            res[b] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] atanh_fx(logic [63:0] num, logic [63:0] den);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] sum;
      int n;
      z    = div_fx(num, den);
      z2   = mul_fx(z, z);
      term = z;
      sum  = '0;
      for (n = 0; n < 64; n++) begin
         if (term != 64'd0) begin
            sum  = sum + udiv_fx(term, 64'(2 * n + 1));
            term = mul_fx(term, z2);
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] ln_fx(logic [63:0] n, logic [63:0] ln2);
      logic [63:0] k;
      logic [63:0] p;
      int t;
      k = '0;
      for (t = 1; t <= ADDR_W; t++) begin
         if ((64'd1 << t) <= n) begin
            k = 64'(t);
         end
      end
      p = 64'd1 << k;
      return k * ln2 + 64'd2 * atanh_fx(n - p, n + p);
   endfunction

   function automatic log_rom_type build_log_rom();
      log_rom_type rom;
      logic [63:0] ln2;
      logic [63:0] ln_top;
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] rh;
      logic [63:0] rl;
      logic [63:0] y;
      logic [63:0] x;
      int j;
      rom    = '0;
      ln2    = 64'd2 * atanh_fx(64'd1, 64'd3);
      ln_top = ln_fx(64'(LOG_TABLE_DEPTH), ln2);
      for (j = 1; j <= LOG_TABLE_DEPTH; j++) begin
         a  = ln_top - ln_fx(64'(j), ln2);
         r  = div_fx(a, ln_top);
         rh = r >> 30;
         rl = r & 64'h3fff_ffff;
         y  = ROM_SCALE * rl + (64'd1 << (FRAC_BITS - 1));
         x  = ROM_SCALE * rh + (y >> 30);
         rom[j] = x[59:30];
      end
      return rom;
   endfunction

   // entries 0 and 511 stay zero and are never hit by the search
   localparam log_rom_type LOG_ROM = build_log_rom();

endpackage

/* rtl/core/gcl_search.sv */
// Pipelined binary search of the log ROM, one address bit per stage.
`timescale 1ns / 1ps

module gcl_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  gcl_pkg::gcl_ctl_type        ctl_in,
   input  logic [gcl_pkg::PRODUCT_W-1:0] y_in,
   output gcl_pkg::gcl_ctl_type        ctl_out,
   output logic [gcl_pkg::ADDR_W-1:0]  index_out
);
   import gcl_pkg::*;

   gcl_ctl_type            ctl_ff [0:SEARCH_STAGES-1];
   logic [ADDR_W-1:0]      m_ff   [0:SEARCH_STAGES-1];
   logic [PRODUCT_W-1:0]   y_ff   [0:SEARCH_STAGES-1];

   gcl_ctl_type            ctl_src [0:SEARCH_STAGES-1];
   logic [ADDR_W-1:0]      m_src   [0:SEARCH_STAGES-1];
   logic [PRODUCT_W-1:0]   y_src   [0:SEARCH_STAGES-1];

   for (genvar g = 0; g < SEARCH_STAGES; g++) begin : g_stage
      localparam int LEVEL = SEARCH_STAGES - 1 - g;

      logic [ADDR_W-1:0] cand;
      logic [ROM_W-1:0]  entry;
      logic [ADDR_W-1:0] m_in;

      if (g == 0) begin : g_first
         assign ctl_src[g] = ctl_in;
         assign m_src[g]   = '0;
         assign y_src[g]   = y_in;
      end else begin : g_next
         assign ctl_src[g] = ctl_ff[g-1];
         assign m_src[g]   = m_ff[g-1];
         assign y_src[g]   = y_ff[g-1];
      end

      // advance the index while the probed entry is still above y
      always_comb begin
         cand  = m_src[g] | (ADDR_W'(1) << LEVEL);
         entry = LOG_ROM[cand];
         m_in  = (PRODUCT_W'(entry) > y_src[g]) ? cand : m_src[g];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g] <= '0;
         end else if (advance) begin
            ctl_ff[g] <= ctl_src[g];
         end
         if (advance) begin
            m_ff[g] <= m_in;
            y_ff[g] <= y_src[g];
         end
      end
   end

   assign ctl_out   = ctl_ff[SEARCH_STAGES-1];
   assign index_out = m_ff[SEARCH_STAGES-1];

endmodule

/* rtl/core/gamma_correct_log_table.sv */
// Usage:
// Gamma correction of an 8-bit pixel stream with exponent csr_write_data / 2^14.
// Input channel: req_valid, req_pixel_in; the block drives req_stall.
// Result channel: rsp_valid, rsp_pixel_out; the receiver drives rsp_stall.
// A transaction moves on a rising edge with valid high and stall low.
// The exponent register is written with csr_write_enable and csr_write_data; the user must
// write it only while no transaction is in flight, which the block itself does not enforce;
// it resets to 1.0 (16384). Each result passes the ROM lookup stage, the 16x16 multiply
// stage, nine binary search stages (one ROM address bit each) and the output register.
// Throughput: one transaction per cycle while the receiver does not stall a waiting result.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises until the result is taken; nothing is dropped or repeated.
// Reset clears all valid bits and loads the exponent reset value; the ROM is
// a constant table and needs no initialization.
`timescale 1ns / 1ps

module gamma_correct_log_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gcl_pkg::PIXEL_W-1:0]   req_pixel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gcl_pkg::PIXEL_W-1:0]   rsp_pixel_out,
   input  logic                          csr_write_enable,
   input  logic [gcl_pkg::GAMMA_W-1:0]   csr_write_data
);
   import gcl_pkg::*;
   `include "gamma_correct_log_table_assert.svh"

   logic                    pipe_advance;
   logic [GAMMA_W-1:0]      gamma_ff;

   gcl_ctl_type             lut_ctl_ff;
   gcl_ctl_type             lut_ctl_in;
   logic [MANT_W-1:0]       lut_mant_ff;
   logic [ROM_W-1:0]        lut_entry;

   gcl_ctl_type             mul_ctl_ff;
   logic [PRODUCT_W-1:0]    mul_y_ff;

   gcl_ctl_type             srch_ctl;
   logic [ADDR_W-1:0]       srch_index;
   logic [ADDR_W:0]         srch_count;

   gcl_ctl_type             out_ctl_ff;
   logic [PIXEL_W-1:0]      out_pixel_ff;
   logic [PIXEL_W-1:0]      out_pixel_in;

   // hold everything while a finished result waits
   assign pipe_advance = !(out_ctl_ff.valid && rsp_stall);
   assign req_stall    = !pipe_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
      end else if (csr_write_enable) begin
         gamma_ff <= csr_write_data;
      end
   end

   always_comb begin
      lut_ctl_in.valid = req_valid;
      lut_ctl_in.zero  = (req_pixel_in == '0);
      lut_entry        = LOG_ROM[{req_pixel_in, 1'b0}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lut_ctl_ff <= '0;
         mul_ctl_ff <= '0;
      end else if (pipe_advance) begin
         lut_ctl_ff <= lut_ctl_in;
         mul_ctl_ff <= lut_ctl_ff;
      end
      if (pipe_advance) begin
         lut_mant_ff <= lut_entry[ROM_W-1:ROM_W-MANT_W];
         mul_y_ff    <= PRODUCT_W'(lut_mant_ff) * PRODUCT_W'(gamma_ff);
      end
   end

   gcl_search u_search (
      .clock     (clock),
      .reset     (reset),
      .advance   (pipe_advance),
      .ctl_in    (mul_ctl_ff),
      .y_in      (mul_y_ff),
      .ctl_out   (srch_ctl),
      .index_out (srch_index)
   );

   always_comb begin
      srch_count   = {1'b0, srch_index} + (ADDR_W + 1)'(1);
      out_pixel_in = srch_ctl.zero ? '0 : srch_count[ADDR_W-1:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else if (pipe_advance) begin
         out_ctl_ff <= srch_ctl;
      end
      if (pipe_advance) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign rsp_valid     = out_ctl_ff.valid;
   assign rsp_pixel_out = out_pixel_ff;

   `GCL_ASSERT_IMPL(a_zero_pixel, out_ctl_ff.valid && out_ctl_ff.zero, out_pixel_ff == '0)
   `GCL_ASSERT_NEXT(a_mul_hold, !pipe_advance, $stable(mul_y_ff) && $stable(mul_ctl_ff))
   `GCL_ASSERT_NEXT(a_valid_travel, pipe_advance && lut_ctl_ff.valid, mul_ctl_ff.valid)
   `GCL_ASSERT_IMPL(a_gamma_reset, $past(reset) && !$past(csr_write_enable),
                    gamma_ff == GAMMA_RESET)

endmodule

/* test/gamma_lut_checker.sv */
// Checker for the gamma correction block: predicts each corrected pixel and compares results.
`timescale 1ns / 1ps

module gamma_lut_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [gcl_pkg::PIXEL_W-1:0]   req_pixel_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [gcl_pkg::PIXEL_W-1:0]   rsp_pixel_out,
   input  logic                          csr_write_enable,
   input  logic [gcl_pkg::GAMMA_W-1:0]   csr_write_data,
   output int                            mismatch_count,
   output int                            expected_left
);

   localparam int          CURVE_DEPTH = gcl_pkg::LOG_TABLE_DEPTH;
   localparam int          POINT       = 60;
   localparam logic [63:0] SCALE_30    = 64'h3fff_ffff;

   logic [29:0]                  log_curve [1:CURVE_DEPTH];
   logic [gcl_pkg::GAMMA_W-1:0]  gamma_reg;
   logic [gcl_pkg::PIXEL_W-1:0]  expected_pixels [$];
   logic [gcl_pkg::PIXEL_W-1:0]  want;

   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return wide[123:60];
   endfunction

   function automatic logic [63:0] fx_div(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] res;
      int bit_pos;
      quo = num / den;
      rem = num - quo * den;
      res = quo << POINT;
      for (bit_pos = POINT - 1; bit_pos >= 0; bit_pos--) begin
         rem = rem << 1;
         if (rem >= den) begin
            rem          = rem - den;
            res[bit_pos] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] fx_atanh(logic [63:0] num, logic [63:0] den);
      logic [63:0] z;
      logic [63:0] z_sq;
      logic [63:0] term;
      logic [63:0] acc;
      int n;
      z    = fx_div(num, den);
      z_sq = fx_mul(z, z);
      term = z;
      acc  = '0;
      n    = 0;
      while (n < 64 && term != 64'd0) begin
         acc  = acc + term / 64'(2 * n + 1);
         term = fx_mul(term, z_sq);
         n++;
      end
      return acc;
   endfunction

   function automatic logic [63:0] fx_ln(logic [63:0] n, logic [63:0] ln2);
      logic [63:0] k;
      logic [63:0] pow2;
      k = '0;
      while ((64'd2 << k) <= n) begin
         k++;
      end
      pow2 = 64'd1 << k;
      return k * ln2 + 64'd2 * fx_atanh(n - pow2, n + pow2);
   endfunction

   function automatic logic [gcl_pkg::PIXEL_W-1:0] corrected_pixel(
      logic [gcl_pkg::PIXEL_W-1:0] pix, logic [gcl_pkg::GAMMA_W-1:0] gamma);
      logic [63:0] target;
      int j;
      if (pix == '0) begin
         return '0;
      end
      target = 64'(log_curve[2 * int'(pix)] >> 14) * 64'(gamma);
      j = 1;
      while (j < CURVE_DEPTH && 64'(log_curve[j]) > target) begin
         j++;
      end
      return gcl_pkg::PIXEL_W'(j >> 1);
   endfunction

   initial begin
      logic [63:0] ln2;
      logic [63:0] ln_top;
      logic [63:0] ratio;
      logic [63:0] lo_sum;
      logic [63:0] full;
      int j;
      ln2    = 64'd2 * fx_atanh(64'd1, 64'd3);
      ln_top = fx_ln(64'(CURVE_DEPTH), ln2);
      for (j = 1; j <= CURVE_DEPTH; j++) begin
         ratio  = fx_div(ln_top - fx_ln(64'(j), ln2), ln_top);
         lo_sum = SCALE_30 * (ratio & SCALE_30) + (64'd1 << (POINT - 1));
         full   = SCALE_30 * (ratio >> 30) + (lo_sum >> 30);
         log_curve[j] = full[59:30];
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         gamma_reg = gcl_pkg::GAMMA_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel_out: result with no expectation waiting, actual %0d",
                      rsp_pixel_out);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want) begin
                  $error("pixel_out: expected %0d, actual %0d", want, rsp_pixel_out);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(corrected_pixel(req_pixel_in, gamma_reg));
         end
         if (csr_write_enable) begin
            gamma_reg = csr_write_data;
         end
      end
      expected_left = expected_pixels.size();
   end

endmodule

/* test/tb_gamma_correct_log_table.sv */
// Testbench top for the gamma correction block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_gamma_correct_log_table;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 90;
   localparam int PHASE_COUNT    = 8;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 20;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [gcl_pkg::PIXEL_W-1:0]   req_pixel_in     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic [gcl_pkg::PIXEL_W-1:0]   rsp_pixel_out;
   logic                          csr_write_enable = 1'b0;
   logic [gcl_pkg::GAMMA_W-1:0]   csr_write_data   = '0;

   int mismatch_count;
   int expected_left;
   int quiet_cycles = 0;
   bit no_idle = 1'b0;
   bit long_hold_wanted = 1'b0;

   always #4 clock = ~clock;

   gamma_correct_log_table uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   gamma_lut_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .expected_left    (expected_left)
   );

   function automatic int idle_cycles();
      int roll;
      if (no_idle) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(1, 3);
      end
      if (roll < 96) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [gcl_pkg::PIXEL_W-1:0] random_pixel();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         return '0;
      end
      if (roll < 6) begin
         return '1;
      end
      if (roll < 9) begin
         return gcl_pkg::PIXEL_W'($urandom_range(1, 2));
      end
      return gcl_pkg::PIXEL_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [gcl_pkg::GAMMA_W-1:0] phase_gamma(int phase);
      case (phase)
         0: return 16'd0;
         1: return 16'd65535;
         2: return 16'd36700;
         3: return 16'd1;
         4: return 16'd8192;
         5: return gcl_pkg::GAMMA_RESET;
         default: return gcl_pkg::GAMMA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after the transaction
   task automatic send_pixel(input logic [gcl_pkg::PIXEL_W-1:0] pix);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_left != 0);
   endtask

   task automatic set_gamma(input logic [gcl_pkg::GAMMA_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int b;
      int phase;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd254);
      send_pixel(8'h55);
      send_pixel(8'haa);
      for (b = 0; b < gcl_pkg::PIXEL_W; b++) begin
         send_pixel(gcl_pkg::PIXEL_W'(1 << b));
      end
      send_pixel(8'd127);
      send_pixel(8'd3);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         set_gamma(phase_gamma(phase));
         no_idle = (phase == 2) || (phase == 5);
         if (phase == 5) begin
            long_hold_wanted = 1'b1;
         end
         repeat (PHASE_ITEMS) send_pixel(random_pixel());
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // result side back-pressure
   initial begin
      int hold;
      bit long_hold_done;
      long_hold_done = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold_wanted && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold = LONG_HOLD;
         end else begin
            hold = idle_cycles();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/gcl_pkg.sv
rtl/core/gcl_search.sv
rtl/core/gamma_correct_log_table.sv
test/gamma_lut_checker.sv
test/tb_gamma_correct_log_table.sv
